/* rtl/lfid_pkg.sv */
`timescale 1ns / 1ps

package lfid_pkg;

   localparam int NumDomains = 4;
   localparam int MaxIds     = 256;
   localparam int NumRegs    = 4;

   localparam int IdW        = 9;
   localparam int DomainW    = 2;
   localparam int RegIdxW    = $clog2(NumRegs);
   localparam int PosW       = $clog2(MaxIds);

   // two-level lowest-set search: groups of GroupW bits
   localparam int GroupW     = 16;
   localparam int NumGroups  = MaxIds / GroupW;
   localparam int GroupIdxW  = $clog2(NumGroups);
   localparam int BitIdxW    = $clog2(GroupW);

   typedef enum logic {
      KIND_ALLOC   = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_DOMAIN = 2'd1,
      STATUS_EXHAUSTED = 2'd2,
      STATUS_BAD_ID    = 2'd3
   } status_type;

   typedef struct packed {
      kind_type             kind;
      logic [DomainW-1:0]   domain;
      logic [IdW-1:0]       id_in;
   } req_type;

   typedef struct packed {
      logic [IdW-1:0]       id_out;
      logic                 ok;
      status_type           status;
   } rsp_type;

   typedef logic [MaxIds-1:0] map_type;

endpackage

/* rtl/lowest_free_id_allocator.sv */
`timescale 1ns / 1ps

// Lowest-free ID allocator over four ID domains.
// Request channel (req_valid/req_ready/req_data): allocate the lowest free ID
// of a domain, or release one ID back to it. Response channel (rsp_*): one
// response per request, in request order: id_out, ok and status.
// CSR port: csr_write_en with csr_index/csr_data sets a domain's limit; the
// domain's IDs 1..limit (limit capped at 256) become free, and zero removes it.
// Write CSRs only while no request is in flight.
// Flow: an accepted request is held in an input register, resolved there
// against the free map, and its result is loaded into the response register.
// Throughput is one request per cycle while the response side is not stalled;
// the free map is updated as the response is loaded, so back-to-back requests
// to one domain see each other. The lowest free ID comes from a two-level
// priority search (16 groups of 16 bits) over the addressed domain's map.
// When rsp_ready is low the response register holds, the input register
// still fills, and only then does req_ready drop.
// Reset clears all limits and free maps (no domain exists) and empties both
// registers.
module lowest_free_id_allocator
   import lfid_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,

   input  logic                csr_write_en,
   input  logic [RegIdxW-1:0]  csr_index,
   input  logic [IdW-1:0]      csr_data
);

   logic [IdW-1:0]   limit_ff [NumDomains];
   logic [IdW-1:0]   limit_in [NumDomains];
   map_type          free_ff  [NumDomains];
   map_type          free_in  [NumDomains];

   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_req_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             advance;
   logic             accept;

   map_type          cur_map;
   logic [IdW-1:0]   cur_limit;
   logic [IdW-1:0]   cur_eff;
   logic             dom_exists;

   logic [NumGroups-1:0] group_any;
   logic [NumGroups-1:0] group_first;
   logic [GroupIdxW-1:0] group_idx;
   logic [GroupW-1:0]    group_bits;
   logic [GroupW-1:0]    bit_first;
   logic [BitIdxW-1:0]   bit_idx;
   logic                 found;
   logic [PosW-1:0]      found_pos;

   logic             rel_ok;
   logic [PosW-1:0]  rel_pos;

   logic [IdW-1:0]   csr_eff;
   map_type          csr_map;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Current domain view
   assign cur_map    = free_ff[s1_req_ff.domain];
   assign cur_limit  = limit_ff[s1_req_ff.domain];
   assign cur_eff    = (cur_limit > IdW'(MaxIds)) ? IdW'(MaxIds) : cur_limit;
   assign dom_exists = (cur_limit != '0);

   // Lowest free bit: pick the first nonempty group, then the first bit in it
   always_comb begin
      for (int g = 0; g < NumGroups; g++) begin
         group_any[g] = |cur_map[g*GroupW +: GroupW];
      end
      group_first = group_any & (~group_any + NumGroups'(1));
      group_idx   = '0;
      for (int g = 0; g < NumGroups; g++) begin
         if (group_first[g]) group_idx = group_idx | GroupIdxW'(g);
      end
      group_bits = cur_map[group_idx*GroupW +: GroupW];
      bit_first  = group_bits & (~group_bits + GroupW'(1));
      bit_idx    = '0;
      for (int b = 0; b < GroupW; b++) begin
         if (bit_first[b]) bit_idx = bit_idx | BitIdxW'(b);
      end
   end

   assign found     = |group_any;
   assign found_pos = {group_idx, bit_idx};

   assign rel_ok  = (s1_req_ff.id_in != '0) && (s1_req_ff.id_in <= cur_eff);
   assign rel_pos = PosW'(s1_req_ff.id_in - IdW'(1));

   // Fresh map for a CSR write: IDs 1..limit free
   assign csr_eff = (csr_data > IdW'(MaxIds)) ? IdW'(MaxIds) : csr_data;
   always_comb begin
      for (int i = 0; i < MaxIds; i++) begin
         csr_map[i] = (IdW'(i) < csr_eff);
      end
   end

   always_comb begin
      rsp_data_in.id_out = '0;
      rsp_data_in.ok     = 1'b0;
      rsp_data_in.status = STATUS_NO_DOMAIN;
      if (dom_exists) begin
         if (s1_req_ff.kind == KIND_ALLOC) begin
            if (found) begin
               rsp_data_in.id_out = IdW'(found_pos) + IdW'(1);
               rsp_data_in.ok     = 1'b1;
               rsp_data_in.status = STATUS_OK;
            end else begin
               rsp_data_in.status = STATUS_EXHAUSTED;
            end
         end else begin
            if (rel_ok) begin
               rsp_data_in.ok     = 1'b1;
               rsp_data_in.status = STATUS_OK;
            end else begin
               rsp_data_in.status = STATUS_BAD_ID;
            end
         end
      end
   end

   always_comb begin
      for (int d = 0; d < NumDomains; d++) begin
         free_in[d]  = free_ff[d];
         limit_in[d] = limit_ff[d];
      end
      if (advance && dom_exists) begin
         if (s1_req_ff.kind == KIND_ALLOC) begin
            if (found) free_in[s1_req_ff.domain][found_pos] = 1'b0;
         end else if (rel_ok) begin
            free_in[s1_req_ff.domain][rel_pos] = 1'b1;
         end
      end
      if (csr_write_en) begin
         limit_in[csr_index] = csr_data;
         free_in[csr_index]  = csr_map;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < NumDomains; d++) begin
            limit_ff[d] <= '0;
            free_ff[d]  <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int d = 0; d < NumDomains; d++) begin
            limit_ff[d] <= limit_in[d];
            free_ff[d]  <= free_in[d];
         end
      end
   end

   // Payload registers: hold unless loaded
   always_ff @(posedge clock) begin
      if (accept) s1_req_ff <= req_data;
      if (advance) rsp_data_ff <= rsp_data_in;
   end

endmodule
